// ----- hw/rtl/wabb_pkg.sv -----
// Shared types, formats and arithmetic helpers for the world box transform.
`timescale 1ns / 1ps
package wabb_pkg;

    localparam int CW = 16;
    localparam int FB = 8;
    localparam int QF = CW - 2;
    localparam int PW = 2 * CW;
    localparam int QW = PW + 1 - QF;
    localparam int RW = QW + 3;
    localparam int TW = PW + 1 - FB;
    localparam int SW = TW + 2;

    localparam int POS_W = 48;
    localparam int ROT_W = 64;
    localparam int SCL_W = 48;
    localparam int CFG_W = 64;

    localparam logic [1:0] CFG_POS = 2'd0;
    localparam logic [1:0] CFG_ROT = 2'd1;
    localparam logic [1:0] CFG_SCL = 2'd2;

    localparam logic [ROT_W-1:0] ROT_RST = ROT_W'(2 ** QF) << (3 * CW);
    localparam logic [SCL_W-1:0] SCL_RST = SCL_W'({3{CW'(2 ** FB)}});

    localparam logic signed [SW-1:0] CMAX = SW'(2 ** (CW - 1) - 1);
    localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

    typedef logic signed [CW-1:0] t_comp;
    typedef t_comp [2:0] t_vec3;
    typedef struct packed {
        t_vec3 bmax;
        t_vec3 bmin;
    } t_box;
    typedef t_comp [2:0][2:0] t_mat;
    typedef logic signed [TW-1:0] t_term;
    typedef t_term [2:0][2:0] t_terms;

    function automatic t_comp sat_comp(input logic signed [SW-1:0] v);
        t_comp res;
        if (v > CMAX) begin
            res = CMAX[CW-1:0];
        end else if (v < CMIN) begin
            res = CMIN[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [PW:0] rnd(input t_comp a, input t_comp b, input int s);
        logic signed [PW-1:0] p;
        logic signed [PW:0] t;
        p = a * b;
        t = (PW + 1)'(p) + (PW + 1)'(2 ** (s - 1));
        return t;
    endfunction

endpackage

// ----- hw/rtl/world_aabb_from_trs_pose_core.sv -----
// Top level: pose registers, five-stage world box pipeline and stream handshake.
//
// Transforms a local box (min and max corners, signed Q8.8) into the world-space
// box of the configured pose translation * rotation(quaternion, not normalized)
// * scale, saturating every result to 16 bits. The pipeline has five register
// stages (quaternion products, rotation entries, scaled matrix, corner
// products, per-axis sums). One box is taken every cycle while the output side is
// ready. Under back-pressure, each stage holds its item and fills bubbles
// independently. The rotation, scale and translation registers feed the first,
// third and fifth stages. Write them only while no box is in flight.
`timescale 1ns / 1ps
module world_aabb_from_trs_pose_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [wabb_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [95:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
    output logic [95:0]                 m_axis_tdata
);
    import wabb_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [ROT_W-1:0] r_rot;
    logic [SCL_W-1:0] r_scl;
    logic [4:0]       r_v;
    logic [4:0]       adv;
    t_mat             mat;
    t_box             box3, wbox;
    t_terms           lo, hi;

    always_comb begin
        adv[4] = !r_v[4] || m_axis_tready;
        for (int k = 3; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = r_v[4];
    assign m_axis_tdata  = wbox;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_pos <= '0;
            r_rot <= ROT_RST;
            r_scl <= SCL_RST;
        end else begin
            if (adv[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < 5; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POS: r_pos <= i_cfg_data[POS_W-1:0];
                    CFG_ROT: r_rot <= i_cfg_data[ROT_W-1:0];
                    CFG_SCL: r_scl <= i_cfg_data[SCL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    wabb_mat u_mat (
        .i_clk (i_clk),
        .i_en  (adv[2:0]),
        .i_rot (r_rot),
        .i_scl (r_scl),
        .i_box (t_box'(s_axis_tdata)),
        .o_mat (mat),
        .o_box (box3)
    );

    wabb_term u_term (
        .i_clk (i_clk),
        .i_en  (adv[3]),
        .i_mat (mat),
        .i_box (box3),
        .o_lo  (lo),
        .o_hi  (hi)
    );

    wabb_sum u_sum (
        .i_clk (i_clk),
        .i_en  (adv[4]),
        .i_pos (r_pos),
        .i_lo  (lo),
        .i_hi  (hi),
        .o_box (wbox)
    );

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline full and stalled");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v[0])
        else $error("accepted item missing from first stage");

    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && adv[4]) |=> r_v[4])
        else $error("item lost between term and sum stages");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && !adv[2]) |=> r_v[2] && r_v[3])
        else $error("stalled item dropped in matrix stage");

endmodule

// ----- hw/rtl/wabb_mat.sv -----
// Pose matrix pipeline: quaternion products, rotation entries, scaled matrix.
`timescale 1ns / 1ps
module wabb_mat (
    input  logic                          i_clk,
    input  logic [2:0]                    i_en,
    input  logic [wabb_pkg::ROT_W-1:0]    i_rot,
    input  logic [wabb_pkg::SCL_W-1:0]    i_scl,
    input  wabb_pkg::t_box                i_box,
    output wabb_pkg::t_mat                o_mat,
    output wabb_pkg::t_box                o_box
);
    import wabb_pkg::*;

    logic signed [QW-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [QW-1:0] n_xx, n_yy, n_zz, n_xy, n_xz, n_yz, n_wx, n_wy, n_wz;
    t_mat r_rm, n_rm;
    t_mat r_mat, n_mat;
    t_box r_box1, r_box2, r_box3;

    function automatic logic signed [QW-1:0] qmul(input t_comp a, input t_comp b);
        logic signed [PW:0] t;
        t = rnd(a, b, QF);
        return QW'(t >>> QF);
    endfunction

    always_comb begin
        t_comp w, x, y, z;
        w = i_rot[4*CW-1:3*CW];
        x = i_rot[3*CW-1:2*CW];
        y = i_rot[2*CW-1:CW];
        z = i_rot[CW-1:0];
        n_xx = qmul(x, x);
        n_yy = qmul(y, y);
        n_zz = qmul(z, z);
        n_xy = qmul(x, y);
        n_xz = qmul(x, z);
        n_yz = qmul(y, z);
        n_wx = qmul(w, x);
        n_wy = qmul(w, y);
        n_wz = qmul(w, z);
    end

    always_comb begin
        logic signed [RW-1:0] one;
        logic signed [RW-1:0] e [3][3];
        one = RW'(2 ** QF);
        e[0][0] = one - ((RW'(r_yy) + RW'(r_zz)) <<< 1);
        e[0][1] = (RW'(r_xy) + RW'(r_wz)) <<< 1;
        e[0][2] = (RW'(r_xz) - RW'(r_wy)) <<< 1;
        e[1][0] = (RW'(r_xy) - RW'(r_wz)) <<< 1;
        e[1][1] = one - ((RW'(r_xx) + RW'(r_zz)) <<< 1);
        e[1][2] = (RW'(r_yz) + RW'(r_wx)) <<< 1;
        e[2][0] = (RW'(r_xz) + RW'(r_wy)) <<< 1;
        e[2][1] = (RW'(r_yz) - RW'(r_wx)) <<< 1;
        e[2][2] = one - ((RW'(r_xx) + RW'(r_yy)) <<< 1);
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                n_rm[c][r] = sat_comp(SW'(e[c][r]));
            end
        end
    end

    always_comb begin
        t_comp s [3];
        t_comp rv;
        logic signed [PW:0] t;
        logic signed [QW-1:0] q;
        s[0] = i_scl[3*CW-1:2*CW];
        s[1] = i_scl[2*CW-1:CW];
        s[2] = i_scl[CW-1:0];
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                rv = r_rm[c][r];
                t = rnd(rv, s[c], QF);
                q = QW'(t >>> QF);
                n_mat[c][r] = sat_comp(SW'(q));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xx <= n_xx; r_yy <= n_yy; r_zz <= n_zz;
            r_xy <= n_xy; r_xz <= n_xz; r_yz <= n_yz;
            r_wx <= n_wx; r_wy <= n_wy; r_wz <= n_wz;
            r_box1 <= i_box;
        end
        if (i_en[1]) begin
            r_rm   <= n_rm;
            r_box2 <= r_box1;
        end
        if (i_en[2]) begin
            r_mat  <= n_mat;
            r_box3 <= r_box2;
        end
    end

    assign o_mat = r_mat;
    assign o_box = r_box3;

endmodule

// ----- hw/rtl/wabb_term.sv -----
// Term stage: matrix entry times box corner, rounded, sorted into min and max.
`timescale 1ns / 1ps
module wabb_term (
    input  logic            i_clk,
    input  logic            i_en,
    input  wabb_pkg::t_mat  i_mat,
    input  wabb_pkg::t_box  i_box,
    output wabb_pkg::t_terms o_lo,
    output wabb_pkg::t_terms o_hi
);
    import wabb_pkg::*;

    t_terms r_lo, r_hi, n_lo, n_hi;

    always_comb begin
        t_comp m, bmn, bmx;
        t_term a, b;
        logic signed [PW:0] ta, tb;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                m   = i_mat[c][r];
                bmn = i_box.bmin[c];
                bmx = i_box.bmax[c];
                ta  = rnd(m, bmn, FB);
                tb  = rnd(m, bmx, FB);
                a   = TW'(ta >>> FB);
                b   = TW'(tb >>> FB);
                if (a < b) begin
                    n_lo[r][c] = a;
                    n_hi[r][c] = b;
                end else begin
                    n_lo[r][c] = b;
                    n_hi[r][c] = a;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

// ----- hw/rtl/wabb_sum.sv -----
// Sum stage: add translation to the three terms per axis and saturate.
`timescale 1ns / 1ps
module wabb_sum (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [wabb_pkg::POS_W-1:0]  i_pos,
    input  wabb_pkg::t_terms            i_lo,
    input  wabb_pkg::t_terms            i_hi,
    output wabb_pkg::t_box              o_box
);
    import wabb_pkg::*;

    t_box r_box, n_box;

    always_comb begin
        t_comp p [3];
        t_term l0, l1, l2, h0, h1, h2;
        p[0] = i_pos[3*CW-1:2*CW];
        p[1] = i_pos[2*CW-1:CW];
        p[2] = i_pos[CW-1:0];
        for (int r = 0; r < 3; r++) begin
            l0 = i_lo[r][0]; l1 = i_lo[r][1]; l2 = i_lo[r][2];
            h0 = i_hi[r][0]; h1 = i_hi[r][1]; h2 = i_hi[r][2];
            n_box.bmin[r] = sat_comp(SW'(p[r]) + SW'(l0) + SW'(l1) + SW'(l2));
            n_box.bmax[r] = sat_comp(SW'(p[r]) + SW'(h0) + SW'(h1) + SW'(h2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the world box transform: directed corners, random poses and boxes.
`timescale 1ns / 1ps
module testbench;
    import wabb_pkg::*;

    localparam logic [1:0] CFG_NONE = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTINGS_N = 10;
    localparam int BOXES_PER_SETTING = 70;

    class pose_scoreboard;
        logic [POS_W-1:0] pos_reg;
        logic [ROT_W-1:0] rot_reg;
        logic [SCL_W-1:0] scl_reg;
        logic [95:0] world_q[$];
        int mismatches;

        function new();
            pos_reg = '0;
            rot_reg = ROT_RST;
            scl_reg = SCL_RST;
            mismatches = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [63:0] d);
            case (idx)
                CFG_POS: pos_reg = d[POS_W-1:0];
                CFG_ROT: rot_reg = d;
                CFG_SCL: scl_reg = d[SCL_W-1:0];
                default: ;
            endcase
        endfunction

        static function longint fld(input logic [CW-1:0] v);
            return longint'($signed(v));
        endfunction

        static function longint round_shift(input longint v, input int s);
            if (s == 0) return v;
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        static function longint clip(input longint v);
            longint hi;
            hi = (longint'(1) <<< (CW - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function void note_box(input logic [95:0] box);
            longint q[4];
            longint xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
            longint rot[3][3];
            longint lo[3];
            longint hi[3];
            longint s, m, a, b, bmin, bmax;
            logic [95:0] world;
            for (int i = 0; i < 4; i++) q[i] = fld(rot_reg[ROT_W-1-CW*i -: CW]);
            one = longint'(1) <<< QF;
            xx = round_shift(q[1] * q[1], QF);
            yy = round_shift(q[2] * q[2], QF);
            zz = round_shift(q[3] * q[3], QF);
            xy = round_shift(q[1] * q[2], QF);
            xz = round_shift(q[1] * q[3], QF);
            yz = round_shift(q[2] * q[3], QF);
            wx = round_shift(q[0] * q[1], QF);
            wy = round_shift(q[0] * q[2], QF);
            wz = round_shift(q[0] * q[3], QF);
            // column-major: rot[column][row]
            rot[0][0] = one - 2 * (yy + zz);
            rot[0][1] = 2 * (xy + wz);
            rot[0][2] = 2 * (xz - wy);
            rot[1][0] = 2 * (xy - wz);
            rot[1][1] = one - 2 * (xx + zz);
            rot[1][2] = 2 * (yz + wx);
            rot[2][0] = 2 * (xz + wy);
            rot[2][1] = 2 * (yz - wx);
            rot[2][2] = one - 2 * (xx + yy);
            for (int r = 0; r < 3; r++) begin
                lo[r] = fld(pos_reg[POS_W-1-CW*r -: CW]);
                hi[r] = lo[r];
            end
            for (int c = 0; c < 3; c++) begin
                s = fld(scl_reg[SCL_W-1-CW*c -: CW]);
                bmin = fld(box[CW*c +: CW]);
                bmax = fld(box[CW*(c+3) +: CW]);
                for (int r = 0; r < 3; r++) begin
                    m = clip(round_shift(clip(rot[c][r]) * s, QF));
                    a = round_shift(m * bmin, FB);
                    b = round_shift(m * bmax, FB);
                    lo[r] += (a < b) ? a : b;
                    hi[r] += (a < b) ? b : a;
                end
            end
            for (int r = 0; r < 3; r++) begin
                world[CW*r +: CW] = CW'(clip(lo[r]));
                world[CW*(r+3) +: CW] = CW'(clip(hi[r]));
            end
            world_q.push_back(world);
        endfunction

        function void check_world(input logic [95:0] got);
            logic [95:0] exp_w;
            if (world_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no box pending: %h", got);
                return;
            end
            exp_w = world_q.pop_front();
            for (int f = 0; f < 6; f++) begin
                if (got[CW*f +: CW] !== exp_w[CW*f +: CW]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("world_%s axis %0d: expected %0d, got %0d",
                                 f < 3 ? "min" : "max", f % 3,
                                 $signed(exp_w[CW*f +: CW]), $signed(got[CW*f +: CW]));
                end
            end
        endfunction

        function int pending();
            return world_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_POS;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
    logic [95:0] m_axis_tdata;

    pose_scoreboard board = new();
    int tx_idle_pct = 21;
    int rx_idle_pct = 60;
    logic [7:0] hold_req = '0;
    logic [7:0] hold_seen = '0;
    int hold_left = 0;
    int stall_cycles = 0;

    world_aabb_from_trs_pose_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_world(m_axis_tdata);
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [95:0] mk_box(input int mnx, mny, mnz, mxx, mxy, mxz);
        return {16'(mxz), 16'(mxy), 16'(mxx), 16'(mnz), 16'(mny), 16'(mnx)};
    endfunction

    task automatic push_box(input logic [95:0] box, input int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= box;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_box(box);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        board.write_reg(idx, d);
    endtask

    // drop valid, drain every pending result, then load the new pose
    task automatic set_pose(input logic [47:0] pos, input logic [63:0] rot,
                            input logic [47:0] scl);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        write_cfg(CFG_POS, {16'($urandom), pos});
        write_cfg(CFG_ROT, rot);
        write_cfg(CFG_SCL, {16'($urandom), scl});
        write_cfg(CFG_NONE, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [95:0] corner_boxes[$];
        logic [47:0] pos_v, scl_v;
        logic [63:0] rot_v;
        logic [95:0] box_v;
        int k, n, j, gap;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        corner_boxes = '{
            mk_box(0, 0, 0, 0, 0, 0),
            mk_box(32767, 32767, 32767, 32767, 32767, 32767),
            mk_box(-32768, -32768, -32768, -32768, -32768, -32768),
            mk_box(-32768, -32768, -32768, 32767, 32767, 32767),
            mk_box(32767, 32767, 32767, -32768, -32768, -32768),
            mk_box(-256, -256, -256, 256, 256, 256),
            mk_box(512, -100, 0, -512, 100, 0),
            mk_box(1, -1, 128, -128, 257, -257),
            mk_box(16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA),
            mk_box(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555)
        };
        // reset pose first, then an unnormalized overflowing pose, then a turn about z
        foreach (corner_boxes[i]) push_box(corner_boxes[i], tx_idle_pct);
        set_pose({3{16'h7FFF}}, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF}, {3{16'h7FFF}});
        for (j = 0; j < 6; j++) push_box(corner_boxes[j], tx_idle_pct);
        set_pose({16'h0100, 16'hFF00, 16'h0080},
                 {16'h2D41, 16'h0000, 16'h0000, 16'h2D41}, {16'h0200, 16'h0100, 16'h8000});
        for (j = 3; j < 7; j++) push_box(corner_boxes[j], tx_idle_pct);

        for (k = 0; k < SETTINGS_N; k++) begin
            if (k == 4) begin
                tx_idle_pct = 60;
                rx_idle_pct = 21;
            end else if (k == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (k)
                0: begin pos_v = '0; rot_v = ROT_RST; scl_v = SCL_RST; end
                1: begin pos_v = '0; rot_v = '0; scl_v = '0; end
                2: begin pos_v = {3{16'h7FFF}}; rot_v = {4{16'h7FFF}}; scl_v = {3{16'h7FFF}}; end
                3: begin pos_v = {3{16'h8000}}; rot_v = {4{16'h8000}}; scl_v = {3{16'h8000}}; end
                4: begin pos_v = '1; rot_v = '1; scl_v = '1; end
                default: begin
                    pos_v = 48'({$urandom, $urandom});
                    scl_v = 48'({$urandom, $urandom});
                    rot_v = {$urandom, $urandom};
                    for (j = 0; j < 3; j++) begin
                        if ($urandom_range(1)) pos_v[16*j +: 16] = 16'(int'($urandom_range(8192)) - 4096);
                        if ($urandom_range(3) != 0)
                            scl_v[16*j +: 16] = 16'(int'($urandom_range(2048)) - 1024);
                    end
                    for (j = 0; j < 4; j++) begin
                        case ($urandom_range(5))
                            0: rot_v[16*j +: 16] = 16'h4000;
                            1: rot_v[16*j +: 16] = 16'hC000;
                            2: rot_v[16*j +: 16] = 16'h2D41;
                            3: rot_v[16*j +: 16] = 16'hD2BF;
                            4: rot_v[16*j +: 16] = 16'h0000;
                            default: ;
                        endcase
                    end
                end
            endcase
            set_pose(pos_v, rot_v, scl_v);
            // stall the output side while items keep coming at full rate
            if (k == 6) hold_req <= hold_req + 8'd1;
            for (n = 0; n < BOXES_PER_SETTING; n++) begin
                box_v = {$urandom, $urandom, $urandom};
                if ($urandom_range(1)) begin
                    for (j = 0; j < 6; j++) box_v[16*j +: 16] = 16'(int'($urandom_range(4096)) - 2048);
                end
                gap = (k == 6 && n < 40) ? 0 : tx_idle_pct;
                push_box(box_v, gap);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
